/* design/fdvp_pkg.sv */
// ----------------------------------------------------------------------------
// fdvp_pkg
// Shared types and constants for the follow drive with voice priority block.
// ----------------------------------------------------------------------------
`default_nettype none

package fdvp_pkg;

	// request kinds on the input channel
	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_TARGET = 2'd1,
		REQ_VOICE  = 2'd2,
		REQ_UNUSED = 2'd3
	} req_type_t;

	// configuration register indexes
	typedef enum logic [3:0] {
		REG_DESIRED_DISTANCE  = 4'd0,
		REG_DISTANCE_DEADBAND = 4'd1,
		REG_BEARING_DEADBAND  = 4'd2,
		REG_FORWARD_GAIN      = 4'd3,
		REG_YAW_GAIN          = 4'd4,
		REG_MAX_FORWARD_SPEED = 4'd5,
		REG_MAX_TURN_RATE     = 4'd6,
		REG_TARGET_TIMEOUT    = 4'd7
	} reg_index_t;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;

	// command codes on the result channel
	localparam logic [3:0] CMD_MOVE = 4'd0;
	localparam logic [3:0] CMD_STOP = 4'd1;

	// voice action codes
	localparam logic [3:0] ACT_DAMP = 4'd1;
	localparam logic [3:0] ACT_LAST = 4'd10;

	localparam logic [7:0] VOICE_HOLD_TICKS = 8'd40;
	localparam logic [7:0] STOP_HOLD_TICKS  = 8'd40;
	localparam logic [7:0] AGE_MAX          = 8'd255;

	// clamped magnitude below this counts as standing still
	localparam logic [14:0] MOVE_EPS = 15'd5;

	// register reset values
	localparam logic [14:0]        RST_DESIRED_DISTANCE  = 15'd4915;
	localparam logic [14:0]        RST_DISTANCE_DEADBAND = 15'd614;
	localparam logic [14:0]        RST_BEARING_DEADBAND  = 15'd328;
	localparam logic signed [15:0] RST_FORWARD_GAIN      = -16'sd1843;
	localparam logic signed [15:0] RST_YAW_GAIN          = -16'sd3277;
	localparam logic [14:0]        RST_MAX_FORWARD_SPEED = 15'd1024;
	localparam logic [14:0]        RST_MAX_TURN_RATE     = 15'd1843;
	localparam logic [7:0]         RST_TARGET_TIMEOUT    = 8'd5;

endpackage

`default_nettype wire

/* design/fdvp_axis.sv */
// ----------------------------------------------------------------------------
// fdvp_axis
// One control axis: deadband, signed Q3.12 gain, rounding and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module fdvp_axis (
	input  logic signed [17:0] err,
	input  logic signed [15:0] gain,
	input  logic        [14:0] deadband,
	input  logic        [14:0] limit,
	output logic signed [15:0] value,
	output logic               quiet
);
	import fdvp_pkg::*;

	logic        [17:0] err_mag;
	logic               active;
	logic signed [33:0] prod;
	logic        [33:0] prod_mag;
	logic        [21:0] rnd;
	logic        [14:0] mag_c;

	always_comb begin
		err_mag  = err[17] ? 18'(-err) : 18'(err);
		active   = err_mag >= {3'b000, deadband};
		prod     = err * gain;
		prod_mag = prod[33] ? 34'(-prod) : 34'(prod);
		// q9.24 to q3.12, round half away from zero
		rnd      = 22'((prod_mag + 34'd2048) >> 12);
		mag_c    = (rnd > {7'd0, limit}) ? limit : rnd[14:0];
		if (!active) begin
			mag_c = '0;
		end
		value = prod[33] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		quiet = mag_c < MOVE_EPS;
	end

endmodule

`default_nettype wire

/* design/follow_drive_with_voice_priority.sv */
// ----------------------------------------------------------------------------
// follow_drive_with_voice_priority
// Follow controller with deadbands and proportional gains; voice commands win.
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while the result register is not stalled;
// the only loop is state written back by the single compute pass between input
// and result register.
// Reset: asynchronous, clears held target, counters and stop flag and loads
// the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module follow_drive_with_voice_priority #(
	// hold lengths in ticks after a voice action
	parameter logic [7:0] VOICE_HOLD = fdvp_pkg::VOICE_HOLD_TICKS,
	parameter logic [7:0] STOP_HOLD  = fdvp_pkg::STOP_HOLD_TICKS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [1:0]                      req_type,
	input  logic signed [15:0]              bearing,
	input  logic signed [15:0]              distance,
	input  logic                            target_finite,
	input  logic [3:0]                      action_code,
	// command channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [3:0]                      command,
	output logic signed [15:0]              forward_speed,
	output logic signed [15:0]              turn_rate,
	// register write port
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fdvp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [fdvp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fdvp_pkg::*;

	// configuration registers
	logic        [14:0] desired_distance_q;
	logic        [14:0] distance_deadband_q;
	logic        [14:0] bearing_deadband_q;
	logic signed [15:0] forward_gain_q;
	logic signed [15:0] yaw_gain_q;
	logic        [14:0] max_forward_speed_q;
	logic        [14:0] max_turn_rate_q;
	logic        [7:0]  target_timeout_q;

	// input register stage
	logic               vld_s1;
	req_type_t          req_s1;
	logic signed [15:0] bearing_s1;
	logic signed [15:0] distance_s1;
	logic               finite_s1;
	logic [3:0]         action_s1;

	// follower state
	logic signed [15:0] held_bearing_q;
	logic signed [15:0] held_distance_q;
	logic               held_finite_q;
	logic               have_target_q;
	logic [7:0]         target_age_q;
	logic [7:0]         hold_remaining_q;
	logic               stop_sent_q;

	// result register
	logic               out_vld_q;
	logic [3:0]         cmd_q;
	logic signed [15:0] fwd_q;
	logic signed [15:0] turn_q;

	// compute pass
	logic               adv;
	logic               take;
	logic [7:0]         age_next;
	logic signed [17:0] dist_err;
	logic signed [17:0] bear_ext;
	logic signed [15:0] fwd_val;
	logic signed [15:0] turn_val;
	logic               fwd_quiet;
	logic               turn_quiet;
	logic               lost;
	logic               emit;
	logic [3:0]         emit_cmd;
	logic signed [15:0] emit_fwd;
	logic signed [15:0] emit_turn;

	// the stage moves when the result register is empty or being drained
	assign adv       = !out_vld_q || !out_stall;
	assign take      = vld_s1 && adv;
	assign in_stall  = vld_s1 && !adv;
	assign cfg_ready = 1'b1;

	assign out_valid     = out_vld_q;
	assign command       = cmd_q;
	assign forward_speed = fwd_q;
	assign turn_rate     = turn_q;

	// register writes, unknown indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_distance_q  <= RST_DESIRED_DISTANCE;
			distance_deadband_q <= RST_DISTANCE_DEADBAND;
			bearing_deadband_q  <= RST_BEARING_DEADBAND;
			forward_gain_q      <= RST_FORWARD_GAIN;
			yaw_gain_q          <= RST_YAW_GAIN;
			max_forward_speed_q <= RST_MAX_FORWARD_SPEED;
			max_turn_rate_q     <= RST_MAX_TURN_RATE;
			target_timeout_q    <= RST_TARGET_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_DESIRED_DISTANCE:  desired_distance_q  <= cfg_data[14:0];
				REG_DISTANCE_DEADBAND: distance_deadband_q <= cfg_data[14:0];
				REG_BEARING_DEADBAND:  bearing_deadband_q  <= cfg_data[14:0];
				REG_FORWARD_GAIN:      forward_gain_q      <= $signed(cfg_data);
				REG_YAW_GAIN:          yaw_gain_q          <= $signed(cfg_data);
				REG_MAX_FORWARD_SPEED: max_forward_speed_q <= cfg_data[14:0];
				REG_MAX_TURN_RATE:     max_turn_rate_q     <= cfg_data[14:0];
				REG_TARGET_TIMEOUT:    target_timeout_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input register: valid is control, payload loads with it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			req_s1      <= req_type_t'(req_type);
			bearing_s1  <= bearing;
			distance_s1 <= distance;
			finite_s1   <= target_finite;
			action_s1   <= action_code;
		end
	end

	// distance error spans -65535..32767, bearing widened to match
	assign dist_err = 18'(held_distance_q) - $signed({3'b000, desired_distance_q});
	assign bear_ext = 18'(held_bearing_q);

	fdvp_axis u_fwd_axis (
		.err      (dist_err),
		.gain     (forward_gain_q),
		.deadband (distance_deadband_q),
		.limit    (max_forward_speed_q),
		.value    (fwd_val),
		.quiet    (fwd_quiet)
	);

	fdvp_axis u_turn_axis (
		.err      (bear_ext),
		.gain     (yaw_gain_q),
		.deadband (bearing_deadband_q),
		.limit    (max_turn_rate_q),
		.value    (turn_val),
		.quiet    (turn_quiet)
	);

	// age counts up before the timeout check, saturating
	assign age_next = (target_age_q == AGE_MAX) ? AGE_MAX : target_age_q + 8'd1;
	assign lost     = !have_target_q || (age_next > target_timeout_q) || !held_finite_q;

	// result decision for the request in the input register
	always_comb begin
		emit      = 1'b0;
		emit_cmd  = CMD_MOVE;
		emit_fwd  = '0;
		emit_turn = '0;
		unique case (req_s1)
			REQ_TICK: begin
				if (hold_remaining_q == 8'd0) begin
					if (lost || (fwd_quiet && turn_quiet)) begin
						// stop goes out only once per standstill
						emit     = !stop_sent_q;
						emit_cmd = CMD_STOP;
					end else begin
						emit      = 1'b1;
						emit_fwd  = fwd_val;
						emit_turn = turn_val;
					end
				end
			end
			REQ_VOICE: begin
				if (action_s1 <= ACT_LAST) begin
					emit     = 1'b1;
					emit_cmd = action_s1 + 4'd1;
				end
			end
			default: ;
		endcase
	end

	// state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_bearing_q   <= '0;
			held_distance_q  <= '0;
			held_finite_q    <= 1'b0;
			have_target_q    <= 1'b0;
			target_age_q     <= '0;
			hold_remaining_q <= '0;
			stop_sent_q      <= 1'b0;
		end else if (take) begin
			unique case (req_s1)
				REQ_TICK: begin
					target_age_q <= age_next;
					if (hold_remaining_q != 8'd0) begin
						hold_remaining_q <= hold_remaining_q - 8'd1;
					end else if (lost || (fwd_quiet && turn_quiet)) begin
						stop_sent_q <= 1'b1;
					end else begin
						stop_sent_q <= 1'b0;
					end
				end
				REQ_TARGET: begin
					held_bearing_q  <= bearing_s1;
					held_distance_q <= distance_s1;
					held_finite_q   <= finite_s1;
					have_target_q   <= 1'b1;
					target_age_q    <= '0;
				end
				REQ_VOICE: begin
					if (action_s1 <= ACT_LAST) begin
						// stop and damp use their own hold length
						hold_remaining_q <= (action_s1 <= ACT_DAMP) ? STOP_HOLD
						                                            : VOICE_HOLD;
						stop_sent_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= take && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			cmd_q  <= emit_cmd;
			fwd_q  <= emit_fwd;
			turn_q <= emit_turn;
		end
	end

endmodule

`default_nettype wire
